@@ hw/rtl/skf_pkg.sv @@
package skf_pkg;

  // Number of fraction bits in estimate, variance, noises and gain.
  localparam int FRAC_BITS = 16;

  localparam int CFG_IDX_W = 2;
  localparam int GAIN_W    = FRAC_BITS + 1;
  localparam int DEN_W     = 33;
  localparam int REM_W     = DEN_W + 1;
  localparam int INNOV_W   = 33;
  localparam int DPROD_W   = INNOV_W + GAIN_W + 1;
  localparam int VPROD_W   = 32 + GAIN_W;
  localparam int DELTA_W   = DPROD_W - FRAC_BITS;
  localparam int WIDE_W    = 48;
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] FRAC_MASK = '1;

  localparam logic signed [15:0] RST_INIT_EST = 16'sd0;
  localparam logic [31:0] RST_INIT_VAR = 32'd65536;
  localparam logic [31:0] RST_PROC_NOISE = 32'd655;
  localparam logic [31:0] RST_MEAS_NOISE = 32'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_EST   = 2'd0,
    REG_INIT_VAR   = 2'd1,
    REG_PROC_NOISE = 2'd2,
    REG_MEAS_NOISE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic capture;
    logic pred;
    logic div_step;
    logic div_first;
    logic mul;
    logic upd;
    logic out_load;
    logic cfg_write;
  } skf_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-31){1'b0}}, {31{1'b1}}};
    lo = {{(WIDE_W-31){1'b1}}, 31'd0};
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = {{(WIDE_W-15){1'b0}}, {15{1'b1}}};
    lo = {{(WIDE_W-15){1'b1}}, 15'd0};
    if (v > hi) begin
      return 16'sh7FFF;
    end else if (v < lo) begin
      return 16'sh8000;
    end else begin
      return v[15:0];
    end
  endfunction

  // Whole units to fixed point, saturated to the signed 32-bit range.
  function automatic logic signed [31:0] scale_whole(input logic signed [15:0] x);
    logic signed [WIDE_W-1:0] w;
    w = WIDE_W'(x);
    w = w <<< FRAC_BITS;
    return sat32(w);
  endfunction

endpackage

@@ hw/rtl/scalar_kalman_filter_int16_top.sv @@
// One-dimensional Kalman filter for signed 16-bit samples. Each accepted
// measurement word updates an internal estimate and error variance and yields
// one filtered word, the estimate truncated toward zero. The block works on one
// sample at a time: an accepted sample passes through the predict, divide,
// multiply, update and done states, the done state loads the output register,
// and then the next sample can be taken. Most of the time goes to the restoring
// divider forming the gain, one bit per cycle; both multiplies run in the same
// cycle. An unread result sits in the output register; a next sample is still
// accepted, but its result waits in the done state until the old word is taken.
// Configuration writes are taken while no sample is in flight, and any write
// reloads the estimate and variance from the initial values.
module scalar_kalman_filter_int16_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          measurement_valid,
  output logic                          measurement_stall,
  input  logic signed [15:0]            measurement,
  output logic                          filtered_valid,
  input  logic                          filtered_stall,
  output logic signed [15:0]            filtered,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  skf_pkg::skf_cmd_t cmd;

  skf_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .measurement_valid (measurement_valid),
    .measurement_stall (measurement_stall),
    .filtered_valid    (filtered_valid),
    .filtered_stall    (filtered_stall),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cmd               (cmd)
  );

  skf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .measurement (measurement),
    .filtered    (filtered)
  );

endmodule

@@ hw/rtl/skf_datapath.sv @@
module skf_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  skf_pkg::skf_cmd_t                 cmd,
  input  logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data,
  input  logic signed [15:0]                measurement,
  output logic signed [15:0]                filtered
);

  logic signed [15:0] init_est;
  logic [31:0]        init_var;
  logic [31:0]        proc_noise;
  logic [31:0]        meas_noise;
  logic signed [15:0] init_est_next;
  logic [31:0]        init_var_next;

  logic signed [31:0] estimate;
  logic [31:0]        variance;
  logic signed [31:0] estimate_next;
  logic [31:0]        variance_next;

  logic signed [15:0]                   meas_q;
  logic [31:0]                          p_q;
  logic [skf_pkg::DEN_W-1:0]            den_q;
  logic signed [skf_pkg::INNOV_W-1:0]   innov_q;
  logic [skf_pkg::REM_W-1:0]            rem;
  logic [skf_pkg::GAIN_W-1:0]           quo;
  logic signed [skf_pkg::DPROD_W-1:0]   dprod;
  logic [skf_pkg::VPROD_W-1:0]          vprod;

  logic [32:0]                          p_sum;
  logic [31:0]                          p_sat;
  logic [skf_pkg::DEN_W-1:0]            den;
  logic signed [31:0]                   m_scaled;
  logic signed [skf_pkg::INNOV_W-1:0]   innov;
  logic [skf_pkg::REM_W-1:0]            shifted;
  logic                                 ge;
  logic [skf_pkg::GAIN_W-1:0]           gain;
  logic signed [skf_pkg::GAIN_W:0]      gain_s;
  logic [skf_pkg::GAIN_W-1:0]           one_minus;
  logic signed [skf_pkg::DPROD_W-1:0]   dbias;
  logic signed [skf_pkg::DPROD_W-1:0]   dsum;
  logic signed [skf_pkg::DELTA_W-1:0]   delta;
  logic signed [skf_pkg::WIDE_W-1:0]    est_sum;
  logic signed [skf_pkg::WIDE_W-1:0]    ebias;
  logic signed [skf_pkg::WIDE_W-1:0]    est_whole;

  // Reload uses the value being written in the same cycle.
  always_comb begin
    init_est_next = init_est;
    init_var_next = init_var;
    if (skf_pkg::cfg_reg_t'(cfg_index) == skf_pkg::REG_INIT_EST) begin
      init_est_next = cfg_data[15:0];
    end
    if (skf_pkg::cfg_reg_t'(cfg_index) == skf_pkg::REG_INIT_VAR) begin
      init_var_next = cfg_data;
    end
  end

  // Predict: saturating variance sum, gain denominator and innovation.
  always_comb begin
    p_sum    = {1'b0, variance} + {1'b0, proc_noise};
    p_sat    = p_sum[32] ? '1 : p_sum[31:0];
    den      = {1'b0, p_sat} + {1'b0, meas_noise};
    m_scaled = skf_pkg::scale_whole(meas_q);
    innov    = skf_pkg::INNOV_W'(m_scaled) - skf_pkg::INNOV_W'(estimate);
  end

  // One restoring division step per cycle. The first step compares the
  // unshifted numerator, which yields the integer bit of the gain.
  always_comb begin
    shifted = cmd.div_first ? {2'b00, p_q} : {rem[skf_pkg::REM_W-2:0], 1'b0};
    ge      = shifted >= {1'b0, den_q};
  end

  always_comb begin
    gain      = (den_q == '0) ? '0 : quo;
    gain_s    = {1'b0, gain};
    one_minus = skf_pkg::GAIN_ONE - gain;
  end

  // Correction: truncate the scaled product toward zero, then saturate.
  always_comb begin
    dbias = dprod[skf_pkg::DPROD_W-1]
          ? skf_pkg::DPROD_W'({1'b0, skf_pkg::FRAC_MASK}) : '0;
    dsum  = dprod + dbias;
    delta = dsum[skf_pkg::DPROD_W-1:skf_pkg::FRAC_BITS];
    est_sum = skf_pkg::WIDE_W'(estimate) + skf_pkg::WIDE_W'(delta);
    estimate_next = skf_pkg::sat32(est_sum);
    variance_next = vprod[skf_pkg::FRAC_BITS +: 32];
  end

  always_comb begin
    ebias = estimate[31] ? skf_pkg::WIDE_W'({1'b0, skf_pkg::FRAC_MASK}) : '0;
    est_whole = (skf_pkg::WIDE_W'(estimate) + ebias) >>> skf_pkg::FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_est   <= skf_pkg::RST_INIT_EST;
      init_var   <= skf_pkg::RST_INIT_VAR;
      proc_noise <= skf_pkg::RST_PROC_NOISE;
      meas_noise <= skf_pkg::RST_MEAS_NOISE;
      estimate   <= skf_pkg::scale_whole(skf_pkg::RST_INIT_EST);
      variance   <= skf_pkg::RST_INIT_VAR;
    end else if (cmd.cfg_write) begin
      case (skf_pkg::cfg_reg_t'(cfg_index))
        skf_pkg::REG_INIT_EST:   init_est   <= init_est_next;
        skf_pkg::REG_INIT_VAR:   init_var   <= init_var_next;
        skf_pkg::REG_PROC_NOISE: proc_noise <= cfg_data;
        skf_pkg::REG_MEAS_NOISE: meas_noise <= cfg_data;
        default: ;
      endcase
      estimate <= skf_pkg::scale_whole(init_est_next);
      variance <= init_var_next;
    end else if (cmd.upd) begin
      estimate <= estimate_next;
      variance <= variance_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      meas_q <= measurement;
    end
    if (cmd.pred) begin
      p_q     <= p_sat;
      den_q   <= den;
      innov_q <= innov;
    end
    if (cmd.div_step) begin
      rem <= ge ? (shifted - skf_pkg::REM_W'(den_q)) : shifted;
      quo <= {quo[skf_pkg::GAIN_W-2:0], ge};
    end
    if (cmd.mul) begin
      dprod <= innov_q * gain_s;
      vprod <= p_q * one_minus;
    end
    if (cmd.out_load) begin
      filtered <= skf_pkg::sat16(est_whole);
    end
  end

endmodule

@@ hw/rtl/skf_ctrl.sv @@
module skf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              measurement_valid,
  output logic              measurement_stall,
  output logic              filtered_valid,
  input  logic              filtered_stall,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  output skf_pkg::skf_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PRED = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_UPD  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [skf_pkg::CNT_W-1:0] cnt;
  logic [skf_pkg::CNT_W-1:0] cnt_next;
  logic                      div_last;
  logic                      filtered_valid_next;

  assign div_last          = cnt == skf_pkg::CNT_W'(skf_pkg::DIV_STEPS - 1);
  assign measurement_stall = state != S_IDLE;
  assign cfg_ready         = state == S_IDLE;

  always_comb begin
    state_next    = state;
    cnt_next      = '0;
    cmd           = '0;
    cmd.cfg_write = cfg_valid && cfg_ready;
    case (state)
      S_IDLE: begin
        if (measurement_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_PRED;
        end
      end
      S_PRED: begin
        cmd.pred   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = cnt == '0;
        if (div_last) begin
          state_next = S_MUL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        // The result register is free once its previous word has been taken.
        if (!filtered_valid || !filtered_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    filtered_valid_next = filtered_valid;
    if (cmd.out_load) begin
      filtered_valid_next = 1'b1;
    end else if (filtered_valid && !filtered_stall) begin
      filtered_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= '0;
      filtered_valid <= 1'b0;
    end else begin
      state          <= state_next;
      cnt            <= cnt_next;
      filtered_valid <= filtered_valid_next;
    end
  end

endmodule

@@ hw/rtl/skf_checker.sv @@
module skf_checker (
  input logic               clk,
  input logic               rst,
  input logic               measurement_valid,
  input logic               measurement_stall,
  input logic               filtered_valid,
  input logic               filtered_stall,
  input logic signed [15:0] filtered,
  input logic               cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    filtered_valid && filtered_stall |=> filtered_valid && $stable(filtered))
    else $error("filtered word changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    measurement_valid && !measurement_stall |=> measurement_stall)
    else $error("second sample accepted while one is in flight");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    measurement_valid && !measurement_stall |=> !$rose(filtered_valid))
    else $error("result appeared before the gain was formed");

  a_cfg_when_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready != measurement_stall)
    else $error("configuration port open while a sample is in flight");

endmodule

bind scalar_kalman_filter_int16_top skf_checker u_skf_checker (
  .clk               (clk),
  .rst               (rst),
  .measurement_valid (measurement_valid),
  .measurement_stall (measurement_stall),
  .filtered_valid    (filtered_valid),
  .filtered_stall    (filtered_stall),
  .filtered          (filtered),
  .cfg_ready         (cfg_ready)
);
